// ----- rtl/machine_description_lexer_core_defines.svh -----
// Assertion helpers for the lexer core.
`ifndef MACHINE_DESCRIPTION_LEXER_CORE_DEFINES_SVH
`define MACHINE_DESCRIPTION_LEXER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MDL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mdl_pkg.sv -----
`default_nettype none
package mdl_pkg;

    localparam int POS_BITS_DEF = 16;

    // Result buffer holds whole per-byte bundles.
    localparam int BUF_DEPTH = 2;
    localparam int BUF_AW    = 1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;

    typedef enum logic [3:0] {
        TK_EOF      = 4'd0,
        TK_FAIL     = 4'd1,
        TK_NAME     = 4'd2,
        TK_STATE    = 4'd3,
        TK_SYMDEF   = 4'd4,
        TK_MATCHDEF = 4'd5,
        TK_WILDDEF  = 4'd6,
        TK_SYM      = 4'd7,
        TK_LCURLY   = 4'd8,
        TK_RCURLY   = 4'd9,
        TK_LMOVE    = 4'd10,
        TK_RMOVE    = 4'd11
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_NAME       = 4'd1,
        PH_ST_OPEN    = 4'd2,
        PH_ST_NAME1   = 4'd3,
        PH_ST_DOT     = 4'd4,
        PH_ST_NAME2   = 4'd5,
        PH_SYM_FIRST  = 4'd6,
        PH_SYM_HEX1   = 4'd7,
        PH_SYM_HEX2   = 4'd8,
        PH_MATCH_1    = 4'd9,
        PH_MATCH_2    = 4'd10,
        PH_MATCH_REST = 4'd11,
        PH_HALT       = 4'd12
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] len;
    } t_token;

    // Tokens caused by one byte; cnt is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_bundle;

    function automatic logic is_word(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F});
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h61:8'h66]});
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c inside {CH_SPACE, CH_TAB, CH_LF});
    endfunction

    function automatic logic is_stop(input logic [7:0] c);
        return is_blank(c) || (c == CH_NUL);
    endfunction

    function automatic t_token fixed_tok(input t_kind k);
        t_token t;
        t.kind  = k;
        t.start = 16'd0;
        t.len   = 16'd0;
        return t;
    endfunction

    // Phase after a fixed token: eof and fail stop the scanner.
    function automatic t_phase fixed_phase(input t_kind k);
        return ((k == TK_EOF) || (k == TK_FAIL)) ? PH_HALT : PH_IDLE;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/machine_description_lexer_core.sv -----
// Channel   Dir  Signals                      Contents
// s_axis    in   tvalid tready tdata[7:0]     source byte (zero = end of text)
// m_axis    out  tvalid tready tdata[31:0]    token start [15:0], token length [31:16]
//                tuser[3:0] tlast             token kind; tlast = last token of its byte
//
// One source byte per cycle. The scanner state registers feed a single layer of
// decode logic that writes a per-byte bundle of zero, one or two tokens into a
// two-entry result buffer; a bundle with two tokens (name ended by a fixed
// token) occupies the output as two words. s_axis_tready drops only when both
// buffer entries hold undelivered bundles. Synchronous active-low reset clears
// the scanner to idle at offset zero and empties the buffer. After eof or fail
// the scanner ignores every byte until reset.
`default_nettype none
`include "machine_description_lexer_core_defines.svh"
module machine_description_lexer_core #(
    parameter int POS_BITS = mdl_pkg::POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] token_start, [31:16] token_len
    output logic [3:0]  o_m_axis_tuser,   // [3:0] token_type
    output logic        o_m_axis_tlast    // last_of_run
);
    import mdl_pkg::*;

    logic    w_fire;
    logic    w_push;
    t_bundle w_bundle;
    t_token  w_tok;

    // a byte is taken only when a whole bundle fits in the buffer
    assign w_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign w_push = w_fire && (w_bundle.cnt != 2'd0);

    mdl_lexer #(
        .POS_BITS (POS_BITS)
    ) u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (i_s_axis_tdata),
        .o_bundle (w_bundle)
    );

    mdl_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_bundle),
        .o_room   (o_s_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_token  (w_tok),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_tok.len, w_tok.start};
    assign o_m_axis_tuser = w_tok.kind;

    // back-pressure on input only while results are waiting
    `MDL_ASSERT_IMPL(a_stall_has_output, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid, "input stalled with empty result buffer")

    // eof and fail are the final tokens: nothing follows once delivered
    `MDL_ASSERT_NEXT(a_halt_drains, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && ((o_m_axis_tuser == TK_EOF) || (o_m_axis_tuser == TK_FAIL)), !o_m_axis_tvalid, "token after eof or fail")

    // a stop token always closes its byte's run
    `MDL_ASSERT_IMPL(a_stop_is_last, i_clk, i_rst_n, o_m_axis_tvalid && ((o_m_axis_tuser == TK_EOF) || (o_m_axis_tuser == TK_FAIL)), o_m_axis_tlast, "eof or fail not last of run")

endmodule
`default_nettype wire

// ----- rtl/mdl_lexer.sv -----
`default_nettype none
module mdl_lexer #(
    parameter int POS_BITS = mdl_pkg::POS_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    output mdl_pkg::t_bundle o_bundle
);
    import mdl_pkg::*;

    t_phase              r_phase, n_phase;
    t_kind               r_pend, n_pend;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_tstart, n_tstart;

    logic [POS_BITS-1:0] w_next;
    logic [POS_BITS-1:0] w_span;

    // idle-phase decode of the current byte
    logic                id_emit;
    t_kind               id_kind;
    t_phase              id_phase;
    logic                id_ld;
    logic [POS_BITS-1:0] id_ts;
    logic                id_pld;
    t_kind               id_pend;
    logic                use_idle;

    function automatic logic [15:0] lo16(input logic [POS_BITS-1:0] v);
        logic [POS_BITS+15:0] e;
        e = {16'd0, v};
        return e[15:0];
    endfunction

    assign w_next = r_pos + {{(POS_BITS-1){1'b0}}, 1'b1};
    assign w_span = r_pos - r_tstart;

    always_comb begin
        id_emit  = 1'b0;
        id_kind  = TK_FAIL;
        id_phase = PH_IDLE;
        id_ld    = 1'b0;
        id_ts    = w_next;
        id_pld   = 1'b0;
        id_pend  = TK_SYMDEF;
        if (!is_blank(i_byte)) begin
            case (i_byte)
                CH_NUL: begin
                    id_emit = 1'b1;
                    id_kind = TK_EOF;
                end
                CH_LCURLY: begin
                    id_emit = 1'b1;
                    id_kind = TK_LCURLY;
                end
                CH_RCURLY: begin
                    id_emit = 1'b1;
                    id_kind = TK_RCURLY;
                end
                CH_LT: begin
                    id_emit = 1'b1;
                    id_kind = TK_LMOVE;
                end
                CH_GT: begin
                    id_emit = 1'b1;
                    id_kind = TK_RMOVE;
                end
                CH_AT: begin
                    id_emit = 1'b1;
                    id_kind = TK_WILDDEF;
                end
                CH_LBRACK: begin
                    id_ld    = 1'b1;
                    id_phase = PH_ST_OPEN;
                end
                CH_BAR, CH_DOLLAR: begin
                    id_ld    = 1'b1;
                    id_pld   = 1'b1;
                    id_pend  = (i_byte == CH_BAR) ? TK_SYMDEF : TK_SYM;
                    id_phase = PH_SYM_FIRST;
                end
                CH_QUEST: begin
                    id_ld    = 1'b1;
                    id_phase = PH_MATCH_1;
                end
                default: begin
                    if (is_word(i_byte)) begin
                        id_ld    = 1'b1;
                        id_ts    = r_pos;
                        id_phase = PH_NAME;
                    end else begin
                        id_emit = 1'b1;
                        id_kind = TK_FAIL;
                    end
                end
            endcase
            if (id_emit) begin
                id_phase = fixed_phase(id_kind);
            end
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_pend        = r_pend;
        n_pos         = r_pos;
        n_tstart      = r_tstart;
        o_bundle.cnt  = 2'd0;
        o_bundle.tok0 = fixed_tok(TK_EOF);
        o_bundle.tok1 = fixed_tok(TK_EOF);
        use_idle      = 1'b0;
        if (i_fire && (r_phase != PH_HALT)) begin
            n_pos = (r_pos != {POS_BITS{1'b1}}) ? w_next : r_pos;
            case (r_phase)
                PH_IDLE: begin
                    use_idle = 1'b1;
                end
                PH_NAME: begin
                    if (!is_word(i_byte)) begin
                        o_bundle.tok0 = '{TK_NAME, lo16(r_tstart), lo16(w_span)};
                        o_bundle.cnt  = 2'd1;
                        use_idle      = 1'b1;
                    end
                end
                PH_ST_OPEN: begin
                    if (is_word(i_byte)) begin
                        n_phase = PH_ST_NAME1;
                    end else if (i_byte == CH_RBRACK) begin
                        o_bundle.tok0 = '{TK_STATE, lo16(r_tstart), 16'd0};
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_IDLE;
                    end else begin
                        o_bundle.tok0 = fixed_tok(TK_FAIL);
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_HALT;
                    end
                end
                PH_ST_NAME1, PH_ST_NAME2: begin
                    if (is_word(i_byte)) begin
                        n_phase = r_phase;
                    end else if ((i_byte == CH_DOT) && (r_phase == PH_ST_NAME1)) begin
                        n_phase = PH_ST_DOT;
                    end else if (i_byte == CH_RBRACK) begin
                        o_bundle.tok0 = '{TK_STATE, lo16(r_tstart), lo16(w_span)};
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_IDLE;
                    end else begin
                        o_bundle.tok0 = fixed_tok(TK_FAIL);
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_HALT;
                    end
                end
                PH_ST_DOT: begin
                    if (is_word(i_byte)) begin
                        n_phase = PH_ST_NAME2;
                    end else begin
                        o_bundle.tok0 = fixed_tok(TK_FAIL);
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_HALT;
                    end
                end
                PH_SYM_FIRST: begin
                    if (is_stop(i_byte)) begin
                        o_bundle.tok0 = fixed_tok(TK_FAIL);
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_HALT;
                    end else if (i_byte == CH_X) begin
                        n_phase = PH_SYM_HEX1;
                    end else begin
                        o_bundle.tok0 = '{r_pend, lo16(r_tstart), 16'd1};
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_IDLE;
                    end
                end
                PH_SYM_HEX1: begin
                    if (is_hex(i_byte)) begin
                        n_phase = PH_SYM_HEX2;
                    end else begin
                        o_bundle.tok0 = fixed_tok(TK_FAIL);
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_HALT;
                    end
                end
                PH_SYM_HEX2: begin
                    o_bundle.cnt = 2'd1;
                    if (is_hex(i_byte)) begin
                        o_bundle.tok0 = '{r_pend, lo16(r_tstart), 16'd3};
                        n_phase       = PH_IDLE;
                    end else begin
                        o_bundle.tok0 = fixed_tok(TK_FAIL);
                        n_phase       = PH_HALT;
                    end
                end
                PH_MATCH_1, PH_MATCH_2: begin
                    if (is_stop(i_byte)) begin
                        o_bundle.tok0 = fixed_tok(TK_FAIL);
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_HALT;
                    end else begin
                        n_phase = (r_phase == PH_MATCH_1) ? PH_MATCH_2 : PH_MATCH_REST;
                    end
                end
                PH_MATCH_REST: begin
                    if (is_blank(i_byte)) begin
                        o_bundle.tok0 = '{TK_MATCHDEF, lo16(r_tstart), lo16(w_span)};
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_IDLE;
                    end else if (i_byte == CH_NUL) begin
                        o_bundle.tok0 = fixed_tok(TK_FAIL);
                        o_bundle.cnt  = 2'd1;
                        n_phase       = PH_HALT;
                    end
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase

            // byte starts a new token after idle or after a name ends
            if (use_idle) begin
                n_phase = id_phase;
                if (id_ld) begin
                    n_tstart = id_ts;
                end
                if (id_pld) begin
                    n_pend = id_pend;
                end
                if (id_emit) begin
                    if (o_bundle.cnt == 2'd0) begin
                        o_bundle.tok0 = fixed_tok(id_kind);
                        o_bundle.cnt  = 2'd1;
                    end else begin
                        o_bundle.tok1 = fixed_tok(id_kind);
                        o_bundle.cnt  = 2'd2;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pend   <= TK_EOF;
            r_pos    <= '0;
            r_tstart <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pend   <= n_pend;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mdl_out_buf.sv -----
`default_nettype none
module mdl_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mdl_pkg::t_bundle i_bundle,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output mdl_pkg::t_token  o_token,
    output logic             o_last
);
    import mdl_pkg::*;

    t_bundle             r_mem [BUF_DEPTH];
    logic [BUF_AW-1:0]   r_wr, n_wr;
    logic [BUF_AW-1:0]   r_rd, n_rd;
    logic [BUF_AW:0]     r_count, n_count;
    logic                r_sub, n_sub;
    logic                w_pop_word;
    logic                w_pop_bundle;
    t_bundle             w_head;

    assign w_head  = r_mem[r_rd];
    assign o_room  = (r_count != BUF_DEPTH[BUF_AW:0]);
    assign o_valid = (r_count != '0);
    assign o_token = r_sub ? w_head.tok1 : w_head.tok0;
    assign o_last  = r_sub || (w_head.cnt != 2'd2);

    assign w_pop_word   = o_valid && i_ready;
    assign w_pop_bundle = w_pop_word && o_last;

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = w_pop_bundle ? r_rd + 1'b1 : r_rd;
        n_sub   = w_pop_word ? !o_last : r_sub;
        n_count = r_count + {{BUF_AW{1'b0}}, i_push} - {{BUF_AW{1'b0}}, w_pop_bundle};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_sub   <= 1'b0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
            r_sub   <= n_sub;
        end
    end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdl_pkg::*;

    localparam int LIMIT_CYCLES = 600000;

    typedef logic [7:0] bytes_t[$];

    // One expected token as it should leave the master side.
    typedef struct {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } tok_t;

    // Scoreboard: tracks the scanner state, queues the tokens each accepted
    // byte should cause, and checks output words against them in order.
    class lex_checker;
        tok_t        tokens_due[$];
        t_phase      phase;
        t_kind       sym_kind;     // symdef or sym while a | or $ token is open
        t_kind       stop_kind;    // eof or fail once the scanner has halted
        logic [15:0] next_pos;     // offset of the next byte, sticks at all ones
        logic [15:0] anchor;       // offset where the open token's text starts
        int          errors;
        int          matched;

        function new();
            phase     = PH_IDLE;
            sym_kind  = TK_EOF;
            stop_kind = TK_EOF;
            next_pos  = 16'd0;
            anchor    = 16'd0;
            errors    = 0;
            matched   = 0;
        endfunction

        static function logic word_ch(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                   (c >= "A" && c <= "Z") || (c == "_");
        endfunction

        static function logic hex_ch(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "f");
        endfunction

        static function logic blank_ch(logic [7:0] c);
            return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
        endfunction

        function void due(t_kind k, logic [15:0] s, logic [15:0] l);
            tok_t t;
            t.kind  = k;
            t.start = s;
            t.len   = l;
            t.last  = 1'b0;
            tokens_due.push_back(t);
        endfunction

        // Fixed tokens carry no text; eof and fail stop the scanner for good.
        function void close_fixed(t_kind k);
            due(k, 16'd0, 16'd0);
            if (k == TK_EOF || k == TK_FAIL) begin
                phase     = PH_HALT;
                stop_kind = k;
            end else begin
                phase = PH_IDLE;
            end
        endfunction

        // Byte seen between tokens. Text of prefixed tokens starts one past p;
        // at a saturated offset that wraps to zero.
        function void open_token(logic [7:0] c, logic [15:0] p);
            if (blank_ch(c))
                return;
            case (c)
                CH_NUL:    close_fixed(TK_EOF);
                CH_LCURLY: close_fixed(TK_LCURLY);
                CH_RCURLY: close_fixed(TK_RCURLY);
                CH_LT:     close_fixed(TK_LMOVE);
                CH_GT:     close_fixed(TK_RMOVE);
                CH_AT:     close_fixed(TK_WILDDEF);
                CH_LBRACK: begin
                    anchor = p + 16'd1;
                    phase  = PH_ST_OPEN;
                end
                CH_BAR, CH_DOLLAR: begin
                    anchor   = p + 16'd1;
                    sym_kind = (c == CH_BAR) ? TK_SYMDEF : TK_SYM;
                    phase    = PH_SYM_FIRST;
                end
                CH_QUEST: begin
                    anchor = p + 16'd1;
                    phase  = PH_MATCH_1;
                end
                default: begin
                    if (word_ch(c)) begin
                        anchor = p;
                        phase  = PH_NAME;
                    end else begin
                        close_fixed(TK_FAIL);
                    end
                end
            endcase
        endfunction

        function void scan_byte(logic [7:0] c);
            logic [15:0] p;
            int          was;
            tok_t        tail;
            if (phase == PH_HALT)
                return;
            p   = next_pos;
            was = tokens_due.size();
            if (next_pos != 16'hFFFF)
                next_pos = next_pos + 16'd1;
            case (phase)
                PH_IDLE: open_token(c, p);
                PH_NAME: begin
                    // the ending byte is scanned again as a fresh token
                    if (!word_ch(c)) begin
                        due(TK_NAME, anchor, p - anchor);
                        phase = PH_IDLE;
                        open_token(c, p);
                    end
                end
                PH_ST_OPEN: begin
                    if (word_ch(c)) begin
                        phase = PH_ST_NAME1;
                    end else if (c == CH_RBRACK) begin
                        due(TK_STATE, anchor, 16'd0);
                        phase = PH_IDLE;
                    end else begin
                        close_fixed(TK_FAIL);
                    end
                end
                PH_ST_NAME1, PH_ST_NAME2: begin
                    if (!word_ch(c)) begin
                        if (c == CH_DOT && phase == PH_ST_NAME1) begin
                            phase = PH_ST_DOT;
                        end else if (c == CH_RBRACK) begin
                            due(TK_STATE, anchor, p - anchor);
                            phase = PH_IDLE;
                        end else begin
                            close_fixed(TK_FAIL);
                        end
                    end
                end
                PH_ST_DOT: begin
                    if (word_ch(c))
                        phase = PH_ST_NAME2;
                    else
                        close_fixed(TK_FAIL);
                end
                PH_SYM_FIRST: begin
                    if (blank_ch(c) || c == CH_NUL) begin
                        close_fixed(TK_FAIL);
                    end else if (c == CH_X) begin
                        phase = PH_SYM_HEX1;
                    end else begin
                        due(sym_kind, anchor, 16'd1);
                        phase = PH_IDLE;
                    end
                end
                PH_SYM_HEX1: begin
                    if (hex_ch(c))
                        phase = PH_SYM_HEX2;
                    else
                        close_fixed(TK_FAIL);
                end
                PH_SYM_HEX2: begin
                    if (hex_ch(c)) begin
                        due(sym_kind, anchor, 16'd3);
                        phase = PH_IDLE;
                    end else begin
                        close_fixed(TK_FAIL);
                    end
                end
                PH_MATCH_1, PH_MATCH_2: begin
                    if (blank_ch(c) || c == CH_NUL)
                        close_fixed(TK_FAIL);
                    else
                        phase = (phase == PH_MATCH_1) ? PH_MATCH_2 : PH_MATCH_REST;
                end
                PH_MATCH_REST: begin
                    if (blank_ch(c)) begin
                        due(TK_MATCHDEF, anchor, p - anchor);
                        phase = PH_IDLE;
                    end else if (c == CH_NUL) begin
                        close_fixed(TK_FAIL);
                    end
                end
                default: phase = PH_HALT;
            endcase
            // flag the final token of this byte
            if (tokens_due.size() > was) begin
                tail      = tokens_due.pop_back();
                tail.last = 1'b1;
                tokens_due.push_back(tail);
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task match_token(logic [3:0] kind, logic [15:0] start, logic [15:0] len,
                         logic last);
            tok_t want;
            if (tokens_due.size() == 0) begin
                report($sformatf("unexpected token kind %0d start %0d len %0d last %0d",
                                 kind, start, len, last));
                return;
            end
            want = tokens_due.pop_front();
            matched++;
            if (kind !== want.kind)
                report($sformatf("token %0d kind %0d, want %0d", matched, kind, want.kind));
            if (start !== want.start)
                report($sformatf("token %0d start %0d, want %0d", matched, start, want.start));
            if (len !== want.len)
                report($sformatf("token %0d len %0d, want %0d", matched, len, want.len));
            if (last !== want.last)
                report($sformatf("token %0d tlast %0d, want %0d", matched, last, want.last));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic [3:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    lex_checker  sb;
    bytes_t      text_q;          // source text waiting to be fed
    logic        prev_name = 1'b0; // last generated token was a name
    int          idle_pct = 0;    // sender: chance of an empty cycle before a word
    int          stall_pct = 0;   // receiver: chance of tready low in a cycle
    int          bytes_fed = 0;
    int          cycle_cnt = 0;

    machine_description_lexer_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),         // [7:0] in_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [15:0] token_start, [31:16] token_len
        .o_m_axis_tuser  (o_m_axis_tuser),  // [3:0] token_type
        .o_m_axis_tlast  (o_m_axis_tlast)   // last_of_run
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Output side: values read right after the edge are the ones the edge saw.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready)
                sb.match_token(o_m_axis_tuser, o_m_axis_tdata[15:0],
                               o_m_axis_tdata[31:16], o_m_axis_tlast);
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offer one byte, with a random gap first, and hold it until taken.
    // tvalid stays high between back-to-back words.
    task automatic push_byte(input logic [7:0] c);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.scan_byte(c);
        bytes_fed++;
    endtask

    task automatic feed_text();
        while (text_q.size() > 0)
            push_byte(text_q.pop_front());
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] word_pick();
        int n;
        n = $urandom_range(0, 62);
        if (n < 10)
            return 8'("0" + n);
        if (n < 36)
            return 8'("A" + n - 10);
        if (n < 62)
            return 8'("a" + n - 36);
        return "_";
    endfunction

    function automatic logic [7:0] hex_pick();
        int n;
        n = $urandom_range(0, 15);
        return (n < 10) ? 8'("0" + n) : 8'("a" + n - 10);
    endfunction

    function automatic logic [7:0] blank_pick();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_LF;
        endcase
    endfunction

    // Any byte that neither ends text nor counts as whitespace.
    function automatic logic [7:0] glyph_pick();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (lex_checker::blank_ch(c));
        return c;
    endfunction

    function automatic bytes_t rand_name(input int n);
        bytes_t q;
        for (int i = 0; i < n; i++)
            q.push_back(word_pick());
        return q;
    endfunction

    // Append one well-formed token with random content. A name followed by
    // something starting with a word char needs a blank or the two merge.
    task automatic make_token();
        bytes_t     body;
        logic [7:0] c;
        int         kind;
        int         k;
        kind = $urandom_range(0, 6);
        case (kind)
            0, 1: body = rand_name($urandom_range(1, 8));
            2: begin
                // state ref: empty, single name, or dotted pair
                k = $urandom_range(0, 2);
                body.push_back(CH_LBRACK);
                if (k > 0)
                    body = {body, rand_name($urandom_range(1, 5))};
                if (k == 2) begin
                    body.push_back(CH_DOT);
                    body = {body, rand_name($urandom_range(1, 5))};
                end
                body.push_back(CH_RBRACK);
            end
            3: begin
                // | or $ with a raw char or an x-escaped hex pair; a raw x
                // always opens the hex form
                body.push_back(($urandom_range(0, 1) == 1) ? CH_BAR : CH_DOLLAR);
                c = glyph_pick();
                if (c == CH_X || $urandom_range(0, 3) == 0) begin
                    body.push_back(CH_X);
                    body.push_back(hex_pick());
                    body.push_back(hex_pick());
                end else begin
                    body.push_back(c);
                end
            end
            4: begin
                body.push_back(CH_QUEST);
                repeat ($urandom_range(2, 6))
                    body.push_back(glyph_pick());
                body.push_back(blank_pick());
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       body.push_back(CH_LCURLY);
                    1:       body.push_back(CH_RCURLY);
                    2:       body.push_back(CH_LT);
                    3:       body.push_back(CH_GT);
                    default: body.push_back(CH_AT);
                endcase
            end
        endcase
        if ((prev_name && lex_checker::word_ch(body[0])) || $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 2))
                text_q.push_back(blank_pick());
        end
        text_q    = {text_q, body};
        prev_name = (kind <= 1);
    endtask

    // Close the stream: eof, or one of the ways a token can go wrong.
    task automatic end_text();
        text_q.push_back(CH_SPACE);
        case ($urandom_range(0, 12))
            0: text_q.push_back(CH_NUL);
            1: begin                      // name and eof from one byte
                add_text("ab");
                text_q.push_back(CH_NUL);
            end
            2: add_text("#");
            3: text_q.push_back(8'($urandom_range(128, 255)));
            4: add_text("[.");
            5: add_text("[a.]");
            6: add_text("| ");
            7: add_text("$xg");
            8: add_text("|xaF");         // upper-case hex digit
            9: begin                      // match text too short
                add_text("?a");
                text_q.push_back(CH_LF);
            end
            10: begin                     // match text cut off by end of text
                add_text("?abc");
                text_q.push_back(CH_NUL);
            end
            11: add_text("[ab{");
            default: add_text("ab~");     // name and fail from one byte
        endcase
        feed_text();
    endtask

    initial begin
        int goal;
        int ignored;
        sb = new();
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: name cut by a fixed token (two tokens on one byte), empty
        // and dotted state refs, non-ASCII and hex symbols, match, fixed tokens.
        add_text("a9{[][_.Z]|");
        text_q.push_back(8'hFF);
        add_text("$x7f?~!");
        text_q.push_back(CH_TAB);
        add_text("<>@}");
        feed_text();

        // Random token streams under four pacing modes.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            goal = bytes_fed + 270;
            while (bytes_fed < goal) begin
                make_token();
                feed_text();
            end
        end

        // A few more tokens under mixed pacing, then end the text.
        idle_pct  = 18;
        stall_pct = 18;
        repeat (30) begin
            make_token();
            feed_text();
        end
        end_text();

        // Halted now: these bytes must be swallowed without output.
        ignored = bytes_fed;
        repeat (6)
            push_byte(8'($urandom_range(0, 255)));
        ignored = bytes_fed - ignored;
        s_tvalid <= 1'b0;

        while (sb.tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Lexed %0d bytes (%0d after halt), checked %0d tokens; stream ended in %s.",
                 bytes_fed, ignored, sb.matched, sb.stop_kind.name());
        $display("Pacing: free-running, sender gaps, receiver stalls, mixed.");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        while (cycle_cnt < LIMIT_CYCLES)
            @(posedge i_clk);
        $display("timeout after %0d cycles, %0d tokens outstanding",
                 cycle_cnt, sb.tokens_due.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/mdl_pkg.sv
rtl/mdl_lexer.sv
rtl/mdl_out_buf.sv
rtl/machine_description_lexer_core.sv
tb/tb.sv
